[design/compensated_float_sum_defines.svh]
// assertion macros for the compensated float sum block
`ifndef COMPENSATED_FLOAT_SUM_DEFINES_SVH
`define COMPENSATED_FLOAT_SUM_DEFINES_SVH
`ifndef SYNTHESIS
`define KCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`define KCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`else
`define KCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define KCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/kcs_pkg.sv]
// shared types and constants of the compensated float sum block
`timescale 1ns / 1ps
package kcs_pkg;
	localparam int unsigned FP_W = 32;
	localparam logic [FP_W-1:0] FP_POS_ZERO = 32'h0000_0000;
	localparam logic [FP_W-1:0] FP_CANON_NAN = 32'h7FC0_0000;
	localparam logic [FP_W-1:0] FP_SIGN_MASK = 32'h8000_0000;

	typedef logic [FP_W-1:0] fp32_t;

	typedef struct packed {
		fp32_t value_bits;
		logic  has_value;
		logic  is_last;
	} kcs_in_beat_t;

	// true for any nan pattern
	function automatic logic fp_is_nan(input fp32_t x);
		fp_is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction
endpackage

[design/kcs_in_if.sv]
// input channel: value, has_value, is_last with valid/ready
`timescale 1ns / 1ps
interface kcs_in_if import kcs_pkg::*; ();
	logic  valid;
	logic  ready;
	fp32_t value_bits;
	logic  has_value;
	logic  is_last;
	modport source (output valid, value_bits, has_value, is_last, input ready);
	modport sink (input valid, value_bits, has_value, is_last, output ready);
endinterface

[design/kcs_out_if.sv]
// output channel: emitted sum with valid/ready
`timescale 1ns / 1ps
interface kcs_out_if import kcs_pkg::*; ();
	logic  valid;
	logic  ready;
	fp32_t sum_bits;
	modport source (output valid, sum_bits, input ready);
	modport sink (input valid, sum_bits, output ready);
endinterface

[design/compensated_float_sum.sv]
// top level of the kahan compensated binary32 summer
//
// channel   dir  beat
// in_ch     in   value_bits, has_value, is_last
// out_ch    out  sum_bits (one beat per last item)
//
// one item per cycle unless a last item waits on a full output register; the kahan
// update of the item in the input register closes through four chained float adders.
// the output register takes a result as its last item leaves the input register.
// reset clears the valid bits and both state words to +0.
// the input register holds only while a last item waits on a full output register.
`timescale 1ns / 1ps
`include "compensated_float_sum_defines.svh"
module compensated_float_sum import kcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	kcs_in_if.sink      in_ch,
	kcs_out_if.source   out_ch
);
	logic         valid_s1;
	kcs_in_beat_t beat_s1;
	fp32_t        sum_q, comp_q, out_q;
	logic         out_valid_q;
	fp32_t        sum_nx, comp_nx, sum_upd;
	logic         adv_s1;

	// stall only for a last item facing a full output register
	assign adv_s1 = valid_s1 && !(beat_s1.is_last && out_valid_q && !out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			beat_s1 <= '{value_bits: in_ch.value_bits, has_value: in_ch.has_value,
				is_last: in_ch.is_last};
		end
	end

	kcs_kahan_step u_step (
		.value(beat_s1.value_bits), .sum_in(sum_q), .comp_in(comp_q),
		.sum_out(sum_nx), .comp_out(comp_nx)
	);

	assign sum_upd = beat_s1.has_value ? sum_nx : sum_q;

	// running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= FP_POS_ZERO;
			comp_q <= FP_POS_ZERO;
		end else if (adv_s1) begin
			if (beat_s1.is_last) begin
				sum_q <= FP_POS_ZERO;
				comp_q <= FP_POS_ZERO;
			end else if (beat_s1.has_value) begin
				sum_q <= sum_nx;
				comp_q <= comp_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && beat_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && beat_s1.is_last) begin
			out_q <= fp_is_nan(sum_upd) ? FP_CANON_NAN : sum_upd;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.sum_bits = out_q;

	// a closed run leaves cleared state
	`KCS_ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv_s1 && beat_s1.is_last,
		sum_q == FP_POS_ZERO && comp_q == FP_POS_ZERO)
	// an empty non-last item leaves the state alone
	`KCS_ASSERT_NEXT(a_idle_keeps_state, clk, arst_n,
		adv_s1 && !beat_s1.has_value && !beat_s1.is_last, $stable(sum_q) && $stable(comp_q))
	// a pending result is never overwritten
	`KCS_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !out_ch.ready,
		!(adv_s1 && beat_s1.is_last))
	// emitted nans are canonical
	`KCS_ASSERT_NOW(a_canon_nan, clk, arst_n, out_valid_q && fp_is_nan(out_q),
		out_q == FP_CANON_NAN)
endmodule

[design/kcs_fadd.sv]
// combinational binary32 adder, round to nearest even, subnormals kept
`timescale 1ns / 1ps
module kcs_fadd import kcs_pkg::*; (
	input  fp32_t a,
	input  fp32_t b,
	output fp32_t y
);
	logic       sa, sb, sx, sy, big_a;
	logic [7:0] ea_f, eb_f;
	logic [9:0] ex, ey, e_n, e_r, shv;
	logic [23:0] mx, my;
	logic [26:0] fx, fy, fy_sh, nm;
	logic        stk;
	logic [27:0] sm;
	logic [4:0]  lz;
	logic        found;
	logic [9:0]  dd;
	logic        inc;
	logic [24:0] mr;
	logic [23:0] mf;
	logic        a_nan, b_nan, a_inf, b_inf;

	always_comb begin
		sa = a[31];
		sb = b[31];
		ea_f = a[30:23];
		eb_f = b[30:23];
		a_nan = fp_is_nan(a);
		b_nan = fp_is_nan(b);
		a_inf = (ea_f == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (eb_f == 8'hFF) && (b[22:0] == 23'd0);
		// order operands by magnitude
		big_a = a[30:0] >= b[30:0];
		sx = big_a ? sa : sb;
		sy = big_a ? sb : sa;
		ex = {2'b00, (big_a ? ea_f : eb_f)};
		ey = {2'b00, (big_a ? eb_f : ea_f)};
		mx = {(ex != 10'd0), (big_a ? a[22:0] : b[22:0])};
		my = {(ey != 10'd0), (big_a ? b[22:0] : a[22:0])};
		if (ex == 10'd0) ex = 10'd1;
		if (ey == 10'd0) ey = 10'd1;
		// align the smaller operand, keeping a sticky bit
		fx = {mx, 3'b000};
		fy = {my, 3'b000};
		dd = ex - ey;
		if (dd >= 10'd27) begin
			fy_sh = 27'd0;
			stk = |my;
		end else begin
			fy_sh = fy >> dd[4:0];
			stk = |(fy & ((27'd1 << dd[4:0]) - 27'd1));
		end
		fy_sh[0] = fy_sh[0] | stk;
		// add or subtract magnitudes
		if (sx == sy) sm = {1'b0, fx} + {1'b0, fy_sh};
		else sm = {1'b0, fx} - {1'b0, fy_sh};
		// normalize
		lz = 5'd0;
		found = 1'b0;
		shv = 10'd0;
		if (sm[27]) begin
			nm = {sm[27:2], sm[1] | sm[0]};
			e_n = ex + 10'd1;
		end else begin
			for (int i = 26; i >= 0; i--) begin
				if (!found && sm[i]) begin
					found = 1'b1;
					lz = 5'(26 - i);
				end
			end
			if (!found) lz = 5'd26;
			shv = ({5'd0, lz} > (ex - 10'd1)) ? (ex - 10'd1) : {5'd0, lz};
			nm = sm[26:0] << shv[4:0];
			e_n = ex - shv;
		end
		// round to nearest even
		inc = nm[2] & (nm[1] | nm[0] | nm[3]);
		mr = {1'b0, nm[26:3]} + {24'd0, inc};
		if (mr[24]) begin
			mf = mr[24:1];
			e_r = e_n + 10'd1;
		end else begin
			mf = mr[23:0];
			e_r = e_n;
		end
		sy = sx;
		// pack with special cases
		if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) y = FP_CANON_NAN;
		else if (a_inf) y = a;
		else if (b_inf) y = b;
		else if (mf == 24'd0) y = {sa & sb, 31'd0};
		else if (e_r >= 10'd255) y = {sy, 8'hFF, 23'd0};
		else y = {sy, (mf[23] ? e_r[7:0] : 8'd0), mf[22:0]};
	end
endmodule

[design/kcs_kahan_step.sv]
// one kahan update: four chained float add/subtract steps
`timescale 1ns / 1ps
module kcs_kahan_step import kcs_pkg::*; (
	input  fp32_t value,
	input  fp32_t sum_in,
	input  fp32_t comp_in,
	output fp32_t sum_out,
	output fp32_t comp_out
);
	fp32_t adj, diff;

	// adj = value - comp
	kcs_fadd u_adj (.a(value), .b(comp_in ^ FP_SIGN_MASK), .y(adj));
	// new sum = sum + adj
	kcs_fadd u_sum (.a(sum_in), .b(adj), .y(sum_out));
	// diff = new - sum
	kcs_fadd u_dif (.a(sum_out), .b(sum_in ^ FP_SIGN_MASK), .y(diff));
	// comp = diff - adj
	kcs_fadd u_cmp (.a(diff), .b(adj ^ FP_SIGN_MASK), .y(comp_out));
endmodule
